FILE: hw/rtl/lrukv_pkg.sv
// Package for the LRU key-value cache: field widths, register map, opcodes
// and the write-enable bundle shared by the top level and the entry store.
// No dependencies.
`default_nettype none

package lrukv_pkg;

    // Default number of entries
    localparam int CAPACITY_DEF = 16;

    // Item fields
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int S_DATA_W  = KEY_W + VAL_W;
    localparam int M_DATA_W  = VAL_W;

    // Configuration register
    localparam int              CFG_W       = 5;
    localparam logic [CFG_W-1:0] CAP_RESET  = 5'd16;
    localparam int              APB_DATA_W  = 32;
    localparam int              APB_ADDR_W  = 3;
    localparam int              REG_IDX_W   = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 1'b0;

    // Opcodes carried on s_tuser
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // Miss result
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    // Write enables for the entry store
    typedef struct packed {
        logic key_we;
        logic val_we;
        logic rank_we;
    } lrukv_wen_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lru_key_value_cache.sv
// Top level of the LRU key-value cache: sequencer, scan unit and ports.
// Depends on lrukv_pkg and lrukv_store.
//
// Channel   Dir  Handshake         Payload
// s_*       in   tvalid/tready     tuser: opcode; tdata: lookup_key, store_value
// m_*       out  tvalid/tready     tuser: hit;    tdata: read_value
// apb       in   psel/penable      capacity_in_use at byte address 0
//
// Each item makes one scan pass over the entry memories to find the key, a free
// entry and the least recent entry; a put and a get hit then make one pass to
// age ranks. Both passes read one entry per cycle through the single read port.
// s_tready is high only between items. A finished result waits in the output
// register, and the next item is accepted meanwhile; a stalled output holds
// the following get in its result step. Reset is asynchronous and clears all
// entries at once through the valid bits; no clearing pass is needed.
`default_nettype none

module lru_key_value_cache
    import lrukv_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,   // [31:0] lookup_key, [63:32] store_value
    input  wire logic                  s_tuser,   // [0] opcode
    // Output stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_DATA_W-1:0]   m_tdata,   // [31:0] read_value
    output logic                       m_tuser,   // [0] hit
    // Configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CMP_W-1:0] CAP_CMP = CMP_W'(CAPACITY);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_PUSH   = 5'b01000,
        ST_SWEEP  = 5'b10000
    } state_t;

    // Control registers
    state_t              state_reg,       state_next;
    logic [CNT_W-1:0]    cnt_reg,         cnt_next;
    logic                pipe_vld_reg,    pipe_vld_next;
    logic [IDX_W-1:0]    pipe_idx_reg,    pipe_idx_next;
    logic                op_reg,          op_next;
    logic                match_found_reg, match_found_next;
    logic [IDX_W-1:0]    match_idx_reg,   match_idx_next;
    logic [IDX_W-1:0]    match_rank_reg,  match_rank_next;
    logic                free_found_reg,  free_found_next;
    logic [IDX_W-1:0]    free_idx_reg,    free_idx_next;
    logic                lru_found_reg,   lru_found_next;
    logic [IDX_W-1:0]    lru_idx_reg,     lru_idx_next;
    logic [IDX_W-1:0]    lru_rank_reg,    lru_rank_next;
    logic [IDX_W-1:0]    tgt_idx_reg,     tgt_idx_next;
    logic [IDX_W-1:0]    lim_rank_reg,    lim_rank_next;
    logic                lim_all_reg,     lim_all_next;
    logic                do_sweep_reg,    do_sweep_next;
    logic [CAPACITY-1:0] valid_reg,       valid_next;
    logic [CNT_W-1:0]    used_reg,        used_next;
    logic [CFG_W-1:0]    cap_reg,         cap_next;
    logic                m_tvalid_reg,    m_tvalid_next;
    logic                hit_reg,         hit_next;

    // Payload registers
    logic [KEY_W-1:0]    key_reg,         key_next;
    logic [VAL_W-1:0]    val_reg,         val_next;
    logic [VAL_W-1:0]    match_val_reg,   match_val_next;
    logic [VAL_W-1:0]    rdval_reg,       rdval_next;

    // Store interface
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    lrukv_wen_t          wen;
    logic [IDX_W-1:0]    kv_addr;
    logic [IDX_W-1:0]    rank_addr;
    logic [IDX_W-1:0]    rank_wdata;
    logic [KEY_W-1:0]    key_q;
    logic [VAL_W-1:0]    val_q;
    logic [IDX_W-1:0]    rank_q;

    logic [CMP_W-1:0]    cap_ext;
    logic [CMP_W-1:0]    cap_eff;
    logic                fill;
    logic                in_accept;
    logic                cfg_write;

    lrukv_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .clk        (clk),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .wen        (wen),
        .kv_addr    (kv_addr),
        .key_wdata  (key_reg),
        .val_wdata  (val_reg),
        .rank_addr  (rank_addr),
        .rank_wdata (rank_wdata),
        .key_q      (key_q),
        .val_q      (val_q),
        .rank_q     (rank_q)
    );

    // Clamp the configured capacity to 1..CAPACITY
    always_comb
    begin
        cap_ext = CMP_W'(cap_reg);
        if (cap_ext == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (cap_ext > CAP_CMP)
        begin
            cap_eff = CAP_CMP;
        end
        else
        begin
            cap_eff = cap_ext;
        end
    end

    assign fill      = free_found_reg && (CMP_W'(used_reg) < cap_eff);
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite && pready;

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        pipe_vld_next    = pipe_vld_reg;
        pipe_idx_next    = pipe_idx_reg;
        op_next          = op_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        match_rank_next  = match_rank_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        lru_found_next   = lru_found_reg;
        lru_idx_next     = lru_idx_reg;
        lru_rank_next    = lru_rank_reg;
        tgt_idx_next     = tgt_idx_reg;
        lim_rank_next    = lim_rank_reg;
        lim_all_next     = lim_all_reg;
        do_sweep_next    = do_sweep_reg;
        valid_next       = valid_reg;
        used_next        = used_reg;
        cap_next         = cap_reg;
        m_tvalid_next    = m_tvalid_reg;
        hit_next         = hit_reg;
        key_next         = key_reg;
        val_next         = val_reg;
        match_val_next   = match_val_reg;
        rdval_next       = rdval_reg;
        rd_en            = 1'b0;
        rd_addr          = cnt_reg[IDX_W-1:0];
        wen              = '0;
        kv_addr          = tgt_idx_reg;
        rank_addr        = pipe_idx_reg;
        rank_wdata       = '0;

        // Drop a delivered result
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        // Register write
        if (cfg_write && (paddr[APB_ADDR_W-1:2] == REG_CAPACITY))
        begin
            cap_next = pwdata[CFG_W-1:0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next          = s_tuser;
                    key_next         = s_tdata[KEY_W-1:0];
                    val_next         = s_tdata[S_DATA_W-1:KEY_W];
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    lru_found_next   = 1'b0;
                    cnt_next         = '0;
                    pipe_vld_next    = 1'b0;
                    state_next       = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Issue the next entry read
                if (cnt_reg != CAP_CNT)
                begin
                    rd_en         = 1'b1;
                    cnt_next      = cnt_reg + CNT_W'(1);
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = cnt_reg[IDX_W-1:0];
                end
                else
                begin
                    pipe_vld_next = 1'b0;
                end
                // Examine the entry read last cycle
                if (pipe_vld_reg)
                begin
                    if (valid_reg[pipe_idx_reg] && (key_q == key_reg) && !match_found_reg)
                    begin
                        match_found_next = 1'b1;
                        match_idx_next   = pipe_idx_reg;
                        match_rank_next  = rank_q;
                        match_val_next   = val_q;
                    end
                    if (!valid_reg[pipe_idx_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = pipe_idx_reg;
                    end
                    if (valid_reg[pipe_idx_reg] && (!lru_found_reg || (rank_q > lru_rank_reg)))
                    begin
                        lru_found_next = 1'b1;
                        lru_idx_next   = pipe_idx_reg;
                        lru_rank_next  = rank_q;
                    end
                    if (cnt_reg == CAP_CNT)
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end

            ST_DECIDE:
            begin
                cnt_next      = '0;
                pipe_vld_next = 1'b0;
                lim_all_next  = 1'b0;
                if (op_reg == OP_GET)
                begin
                    tgt_idx_next  = match_idx_reg;
                    lim_rank_next = match_rank_reg;
                    do_sweep_next = match_found_reg;
                    state_next    = ST_PUSH;
                end
                else if (match_found_reg)
                begin
                    // Update the value in place
                    kv_addr       = match_idx_reg;
                    wen.val_we    = 1'b1;
                    tgt_idx_next  = match_idx_reg;
                    lim_rank_next = match_rank_reg;
                    state_next    = ST_SWEEP;
                end
                else if (fill)
                begin
                    // Fill the lowest free entry
                    kv_addr                  = free_idx_reg;
                    wen.key_we               = 1'b1;
                    wen.val_we               = 1'b1;
                    valid_next[free_idx_reg] = 1'b1;
                    used_next                = used_reg + CNT_W'(1);
                    tgt_idx_next             = free_idx_reg;
                    lim_all_next             = 1'b1;
                    state_next               = ST_SWEEP;
                end
                else
                begin
                    // Evict the least recent entry
                    kv_addr       = lru_idx_reg;
                    wen.key_we    = 1'b1;
                    wen.val_we    = 1'b1;
                    tgt_idx_next  = lru_idx_reg;
                    lim_rank_next = lru_rank_reg;
                    state_next    = ST_SWEEP;
                end
            end

            ST_PUSH:
            begin
                // Hold until the output register is free, then load the result
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    hit_next      = match_found_reg;
                    rdval_next    = match_found_reg ? match_val_reg : MISS_VALUE;
                    state_next    = do_sweep_reg ? ST_SWEEP : ST_IDLE;
                end
            end

            ST_SWEEP:
            begin
                if (cnt_reg != CAP_CNT)
                begin
                    rd_en         = 1'b1;
                    cnt_next      = cnt_reg + CNT_W'(1);
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = cnt_reg[IDX_W-1:0];
                end
                else
                begin
                    pipe_vld_next = 1'b0;
                end
                // Age entries more recent than the limit (all valid entries on a fill), make the target newest
                if (pipe_vld_reg)
                begin
                    if (pipe_idx_reg == tgt_idx_reg)
                    begin
                        wen.rank_we = 1'b1;
                        rank_wdata  = '0;
                    end
                    else if (valid_reg[pipe_idx_reg] && (lim_all_reg || (rank_q < lim_rank_reg)))
                    begin
                        wen.rank_we = 1'b1;
                        rank_wdata  = rank_q + IDX_W'(1);
                    end
                    if (cnt_reg == CAP_CNT)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            pipe_vld_reg    <= 1'b0;
            pipe_idx_reg    <= '0;
            op_reg          <= OP_GET;
            match_found_reg <= 1'b0;
            match_idx_reg   <= '0;
            match_rank_reg  <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            lru_found_reg   <= 1'b0;
            lru_idx_reg     <= '0;
            lru_rank_reg    <= '0;
            tgt_idx_reg     <= '0;
            lim_rank_reg    <= '0;
            lim_all_reg     <= 1'b0;
            do_sweep_reg    <= 1'b0;
            valid_reg       <= '0;
            used_reg        <= '0;
            cap_reg         <= CAP_RESET;
            m_tvalid_reg    <= 1'b0;
            hit_reg         <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            pipe_vld_reg    <= pipe_vld_next;
            pipe_idx_reg    <= pipe_idx_next;
            op_reg          <= op_next;
            match_found_reg <= match_found_next;
            match_idx_reg   <= match_idx_next;
            match_rank_reg  <= match_rank_next;
            free_found_reg  <= free_found_next;
            free_idx_reg    <= free_idx_next;
            lru_found_reg   <= lru_found_next;
            lru_idx_reg     <= lru_idx_next;
            lru_rank_reg    <= lru_rank_next;
            tgt_idx_reg     <= tgt_idx_next;
            lim_rank_reg    <= lim_rank_next;
            lim_all_reg     <= lim_all_next;
            do_sweep_reg    <= do_sweep_next;
            valid_reg       <= valid_next;
            used_reg        <= used_next;
            cap_reg         <= cap_next;
            m_tvalid_reg    <= m_tvalid_next;
            hit_reg         <= hit_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        val_reg       <= val_next;
        match_val_reg <= match_val_next;
        rdval_reg     <= rdval_next;
    end

    // Register readback
    always_comb
    begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1:2] == REG_CAPACITY)
        begin
            prdata = APB_DATA_W'(cap_reg);
        end
    end

    assign pready   = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = rdval_reg;
    assign m_tuser  = hit_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/lrukv_store.sv
// Entry store of the LRU key-value cache: key, value and age-rank memories
// with one shared registered read port. Depends on lrukv_pkg.
`default_nettype none

module lrukv_store
    import lrukv_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
)
(
    input  wire logic                  clk,
    input  wire logic                  rd_en,
    input  wire logic [IDX_W-1:0]      rd_addr,
    input  wire lrukv_wen_t            wen,
    input  wire logic [IDX_W-1:0]      kv_addr,
    input  wire logic [KEY_W-1:0]      key_wdata,
    input  wire logic [VAL_W-1:0]      val_wdata,
    input  wire logic [IDX_W-1:0]      rank_addr,
    input  wire logic [IDX_W-1:0]      rank_wdata,
    output logic      [KEY_W-1:0]      key_q,
    output logic      [VAL_W-1:0]      val_q,
    output logic      [IDX_W-1:0]      rank_q
);

    logic [KEY_W-1:0] key_mem  [CAPACITY];
    logic [VAL_W-1:0] val_mem  [CAPACITY];
    logic [IDX_W-1:0] rank_mem [CAPACITY];

    // Write ports and registered shared read
    always_ff @(posedge clk)
    begin
        if (wen.key_we)
        begin
            key_mem[kv_addr] <= key_wdata;
        end
        if (wen.val_we)
        begin
            val_mem[kv_addr] <= val_wdata;
        end
        if (wen.rank_we)
        begin
            rank_mem[rank_addr] <= rank_wdata;
        end
        if (rd_en)
        begin
            key_q  <= key_mem[rd_addr];
            val_q  <= val_mem[rd_addr];
            rank_q <= rank_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lrukv_checker.sv
// Port-level checker for the LRU key-value cache, bound to the top level.
// Depends on lrukv_pkg and lru_key_value_cache.
`default_nettype none

module lrukv_checker
    import lrukv_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic                m_tuser
);

    // An accepted transaction keeps the input closed for its scan
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after an accepted transaction");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // A miss reads as all ones
    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == MISS_VALUE))
        else $error("miss result is not all ones");

    // No result is loaded while the block waits for an item
    a_no_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && s_tready) |=> !m_tvalid)
        else $error("result appeared while idle");

endmodule

bind lru_key_value_cache lrukv_checker u_lrukv_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
